// ===== design/assert_macros.svh =====
// Assertion helpers used by the top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, ignored while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// ===== design/tlhm_pkg.sv =====
package tlhm_pkg;

  // Default store sizes
  localparam int TILE_ENTRIES_DEF    = 4096;
  localparam int PACKED_BLOCKS_DEF   = 2048;
  localparam int UNPACKED_BLOCKS_DEF = 1024;

  // Field widths
  localparam int OP_W       = 2;
  localparam int COORD_W    = 8;
  localparam int ADDR_W     = 14;
  localparam int BASE_W     = 12;
  localparam int BLK_W      = 20;
  localparam int BYTE_W     = 8;
  localparam int NIBBLE_W   = 4;
  localparam int HEIGHT_W   = 13;
  localparam int ENTRY_W    = BASE_W + BLK_W;
  localparam int TPR_W      = 7;
  localparam int PBC_W      = 12;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;

  // Tiles are 4x4 samples; a packed block is 8 bytes, an unpacked one 16
  localparam int TILE_SHIFT     = 2;
  localparam int POS_W          = 2 * TILE_SHIFT;
  localparam int PACKED_BPB     = 8;
  localparam int UNPACKED_BPB   = 16;
  // Widest tile index: 63 + 127 * 63
  localparam int TILE_IDX_W     = 13;

  typedef enum logic [OP_W-1:0] {
    OP_TILE_WR     = 2'd0,
    OP_PACKED_WR   = 2'd1,
    OP_UNPACKED_WR = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKED_COUNT  = 1'd1;

  // Query state after the tile table read
  typedef struct packed {
    logic             tile_err;
    logic [POS_W-1:0] pos;
  } tile_rsp_t;

  // Query state after the block store read
  typedef struct packed {
    logic              err;
    logic              packed_sel;
    logic              low_nibble;
    logic [BASE_W-1:0] base;
  } fetch_rsp_t;

endpackage

// ===== design/tlhm_tile_lookup.sv =====
module tlhm_tile_lookup #(
  parameter int TILE_ENTRIES = tlhm_pkg::TILE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          query_en,
  input  logic                          write_en,
  input  logic [tlhm_pkg::COORD_W-1:0]  x,
  input  logic [tlhm_pkg::COORD_W-1:0]  y,
  input  logic [tlhm_pkg::TPR_W-1:0]    tiles_per_row,
  input  logic [tlhm_pkg::ADDR_W-1:0]   write_addr,
  input  logic [tlhm_pkg::ENTRY_W-1:0]  write_entry,
  output tlhm_pkg::tile_rsp_t           rsp,
  output logic [tlhm_pkg::ENTRY_W-1:0]  entry
);
  import tlhm_pkg::*;

  localparam int TILE_AW = (TILE_ENTRIES > 1) ? $clog2(TILE_ENTRIES) : 1;

  logic [ENTRY_W-1:0]    mem [TILE_ENTRIES];
  logic [TILE_IDX_W-1:0] tile_idx;
  logic [31:0]           tile_wide;
  logic [31:0]           waddr_wide;
  logic                  tile_ok;
  logic                  waddr_ok;

  // Tile index: column of tiles plus row of tiles times tiles per row
  assign tile_idx = TILE_IDX_W'(x[COORD_W-1:TILE_SHIFT])
                  + TILE_IDX_W'(tiles_per_row) * TILE_IDX_W'(y[COORD_W-1:TILE_SHIFT]);
  assign tile_wide  = 32'(tile_idx);
  assign waddr_wide = 32'(write_addr);
  assign tile_ok    = tile_wide < 32'(TILE_ENTRIES);
  assign waddr_ok   = waddr_wide < 32'(TILE_ENTRIES);

  always_ff @(posedge clk) begin
    if (write_en && waddr_ok) begin
      mem[waddr_wide[TILE_AW-1:0]] <= write_entry;
    end
    if (query_en) begin
      entry        <= mem[tile_wide[TILE_AW-1:0]];
      rsp.tile_err <= !tile_ok;
      rsp.pos      <= {y[TILE_SHIFT-1:0], x[TILE_SHIFT-1:0]};
    end
  end

endmodule

// ===== design/tlhm_delta_fetch.sv =====
module tlhm_delta_fetch #(
  parameter int PACKED_BLOCKS   = tlhm_pkg::PACKED_BLOCKS_DEF,
  parameter int UNPACKED_BLOCKS = tlhm_pkg::UNPACKED_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         fetch_en,
  input  logic                         packed_wr_en,
  input  logic                         unpacked_wr_en,
  input  logic [tlhm_pkg::ADDR_W-1:0]  write_addr,
  input  logic [tlhm_pkg::BYTE_W-1:0]  data_byte,
  input  logic [tlhm_pkg::PBC_W-1:0]   packed_block_count,
  input  tlhm_pkg::tile_rsp_t          tile_rsp,
  input  logic [tlhm_pkg::ENTRY_W-1:0] entry,
  output tlhm_pkg::fetch_rsp_t         rsp,
  output logic [tlhm_pkg::BYTE_W-1:0]  packed_byte,
  output logic [tlhm_pkg::BYTE_W-1:0]  unpacked_byte
);
  import tlhm_pkg::*;

  localparam int PACKED_BYTES   = PACKED_BLOCKS * PACKED_BPB;
  localparam int UNPACKED_BYTES = UNPACKED_BLOCKS * UNPACKED_BPB;
  localparam int PACKED_AW      = $clog2(PACKED_BYTES);
  localparam int UNPACKED_AW    = $clog2(UNPACKED_BYTES);

  logic [BYTE_W-1:0] packed_mem   [PACKED_BYTES];
  logic [BYTE_W-1:0] unpacked_mem [UNPACKED_BYTES];

  logic [BLK_W-1:0] blk;
  logic [BLK_W-1:0] ublk;
  logic             packed_sel;
  logic             blk_err;
  logic [31:0]      waddr_wide;
  logic [31:0]      paddr_wide;
  logic [31:0]      uaddr_wide;

  assign blk        = entry[ENTRY_W-1:BASE_W];
  assign packed_sel = blk < BLK_W'(packed_block_count);
  assign ublk       = blk - BLK_W'(packed_block_count);
  assign blk_err    = packed_sel ? (32'(blk) >= 32'(PACKED_BLOCKS))
                                 : (32'(ublk) >= 32'(UNPACKED_BLOCKS));
  assign waddr_wide = 32'(write_addr);
  // Packed: two samples per byte; unpacked: one byte per sample
  assign paddr_wide = 32'({blk, tile_rsp.pos[POS_W-1:1]});
  assign uaddr_wide = 32'({ublk, tile_rsp.pos});

  always_ff @(posedge clk) begin
    if (packed_wr_en && (waddr_wide < 32'(PACKED_BYTES))) begin
      packed_mem[waddr_wide[PACKED_AW-1:0]] <= data_byte;
    end
    if (unpacked_wr_en && (waddr_wide < 32'(UNPACKED_BYTES))) begin
      unpacked_mem[waddr_wide[UNPACKED_AW-1:0]] <= data_byte;
    end
    if (fetch_en) begin
      packed_byte    <= packed_mem[paddr_wide[PACKED_AW-1:0]];
      unpacked_byte  <= unpacked_mem[uaddr_wide[UNPACKED_AW-1:0]];
      rsp.err        <= tile_rsp.tile_err || blk_err;
      rsp.packed_sel <= packed_sel;
      rsp.low_nibble <= tile_rsp.pos[0];
      rsp.base       <= entry[BASE_W-1:0];
    end
  end

endmodule

// ===== design/tiled_heightmap_point_decode.sv =====
// Height map point decoder. Each word on the input channel is either a load
// (tile entry, packed delta byte or unpacked delta byte, written at
// write_addr) or a query of sample (x, y). Only a query returns a word:
// height = tile base + 4-bit or 8-bit delta, or height 0 with range_error set
// when the tile index or the block lies past its store. Loads past a store
// are dropped silently. The block takes one word per cycle while in_stall is
// low, loads and queries mixed freely; a query reads the tile table at the
// edge that accepts it, then the block store, and then the output register
// loads. Bubbles collapse, so input keeps flowing while a finished word waits
// at a stalled output until the pipeline fills. Stores need no clearing after
// reset; reading an entry never loaded returns arbitrary data.
// Write tiles_per_row (index 0, reset 64) and packed_block_count (index 1,
// reset 0) only while the block is idle.
`include "assert_macros.svh"

module tiled_heightmap_point_decode #(
  parameter int TILE_ENTRIES    = tlhm_pkg::TILE_ENTRIES_DEF,
  parameter int PACKED_BLOCKS   = tlhm_pkg::PACKED_BLOCKS_DEF,
  parameter int UNPACKED_BLOCKS = tlhm_pkg::UNPACKED_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [tlhm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlhm_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tlhm_pkg::OP_W-1:0]      op,
  input  logic [tlhm_pkg::COORD_W-1:0]   x,
  input  logic [tlhm_pkg::COORD_W-1:0]   y,
  input  logic [tlhm_pkg::ADDR_W-1:0]    write_addr,
  input  logic [tlhm_pkg::BASE_W-1:0]    base_height,
  input  logic [tlhm_pkg::BLK_W-1:0]     block_index,
  input  logic [tlhm_pkg::BYTE_W-1:0]    data_byte,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tlhm_pkg::HEIGHT_W-1:0]  height,
  output logic                           range_error
);
  import tlhm_pkg::*;

  logic [TPR_W-1:0] tiles_per_row;
  logic [PBC_W-1:0] packed_block_count;

  logic s1_valid;
  logic s2_valid;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic s1_go;
  logic accept;
  logic query_accept;

  tile_rsp_t          tile_rsp;
  logic [ENTRY_W-1:0] entry;
  fetch_rsp_t         fetch_rsp;
  logic [BYTE_W-1:0]  packed_byte;
  logic [BYTE_W-1:0]  unpacked_byte;
  logic [BYTE_W-1:0]  delta;
  logic [HEIGHT_W-1:0] height_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_per_row      <= TPR_W'(64);
      packed_block_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILES_PER_ROW: tiles_per_row      <= cfg_data[TPR_W-1:0];
        REG_PACKED_COUNT:  packed_block_count <= cfg_data[PBC_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage flow: each stage advances when the one after it is empty or moving.
  assign out_free     = !out_valid || !out_stall;
  assign s2_free      = !s2_valid || out_free;
  assign s1_free      = !s1_valid || s2_free;
  assign s1_go        = s1_valid && s2_free;
  assign in_stall     = !s1_free;
  assign accept       = in_valid && s1_free;
  // Only queries occupy a pipeline slot; loads write their store and vanish.
  assign query_accept = accept && (op == OP_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= query_accept;
      end
      if (s2_free) begin
        s2_valid <= s1_go;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Tile table: loads write at acceptance, a query reads in the same edge.
  tlhm_tile_lookup #(
    .TILE_ENTRIES (TILE_ENTRIES)
  ) u_tile (
    .clk           (clk),
    .query_en      (query_accept),
    .write_en      (accept && (op == OP_TILE_WR)),
    .x             (x),
    .y             (y),
    .tiles_per_row (tiles_per_row),
    .write_addr    (write_addr),
    .write_entry   ({block_index, base_height}),
    .rsp           (tile_rsp),
    .entry         (entry)
  );

  // Block stores: a later load can only be accepted on the edge that moves
  // the earlier query out of stage 1, so the query reads the old byte.
  tlhm_delta_fetch #(
    .PACKED_BLOCKS   (PACKED_BLOCKS),
    .UNPACKED_BLOCKS (UNPACKED_BLOCKS)
  ) u_fetch (
    .clk                (clk),
    .fetch_en           (s1_go),
    .packed_wr_en       (accept && (op == OP_PACKED_WR)),
    .unpacked_wr_en     (accept && (op == OP_UNPACKED_WR)),
    .write_addr         (write_addr),
    .data_byte          (data_byte),
    .packed_block_count (packed_block_count),
    .tile_rsp           (tile_rsp),
    .entry              (entry),
    .rsp                (fetch_rsp),
    .packed_byte        (packed_byte),
    .unpacked_byte      (unpacked_byte)
  );

  // Even x takes the high nibble, odd x the low one
  always_comb begin
    if (fetch_rsp.packed_sel) begin
      delta = fetch_rsp.low_nibble ? BYTE_W'(packed_byte[NIBBLE_W-1:0])
                                   : BYTE_W'(packed_byte[BYTE_W-1:NIBBLE_W]);
    end else begin
      delta = unpacked_byte;
    end
    height_next = fetch_rsp.err ? '0
                                : HEIGHT_W'(fetch_rsp.base) + HEIGHT_W'(delta);
  end

  // Output register: hold while the word is stalled
  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      height      <= height_next;
      range_error <= fetch_rsp.err;
    end
  end

  `ASSERT_CLK_RST(a_load_no_slot, clk, rst,
    (accept && (op != OP_QUERY)) |=> !s1_valid, "load took a pipeline slot")
  `ASSERT_CLK_RST(a_s1_hold, clk, rst,
    (s1_valid && !s2_free) |=> s1_valid, "stage 1 query dropped while blocked")
  `ASSERT_CLK_RST(a_out_from_s2, clk, rst,
    $rose(out_valid) |-> $past(s2_valid), "output word without stage 2 source")
  `ASSERT_CLK_RST(a_err_zero, clk, rst,
    (out_valid && range_error) |-> (height == '0), "range error with nonzero height")

endmodule
